/* sv/sav_pkg.sv */
// Shared types, constants and register codes of the sensor averaging and alarm block.
`default_nettype none
package sav_pkg;

	// Window length; a power of two, so the average is an arithmetic shift.
	localparam int WINDOW_LEN  = 8;
	localparam int WINDOW_LOG2 = $clog2(WINDOW_LEN);
	localparam int POS_W       = WINDOW_LOG2;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

	// Stored sample widths and running sum widths.
	localparam int TEMP_W      = 12;
	localparam int HUM_W       = 11;
	localparam int GAS_W       = 12;
	localparam int LIGHT_W     = 16;
	localparam int TEMP_SUM_W  = TEMP_W + WINDOW_LOG2;
	localparam int HUM_SUM_W   = HUM_W + WINDOW_LOG2;
	localparam int GAS_SUM_W   = GAS_W + WINDOW_LOG2;
	localparam int LIGHT_SUM_W = LIGHT_W + WINDOW_LOG2;

	// Range check of the calibrated reading, tenths of a unit.
	localparam logic signed [11:0] TEMP_VALID_MIN = -12'sd400;
	localparam logic signed [11:0] TEMP_VALID_MAX = 12'sd800;
	localparam logic signed [11:0] HUM_VALID_MIN  = 12'sd0;
	localparam logic signed [11:0] HUM_VALID_MAX  = 12'sd1000;

	// Output clamp of the temperature on the pass-through path.
	localparam logic signed [11:0] TEMP_SAT_MAX = 12'sd1023;
	localparam logic signed [11:0] TEMP_SAT_MIN = -12'sd1024;

	// Configuration port.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_OFFSET     = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HUM_OFFSET      = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAS_LIMIT       = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW_LIMIT  = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH_LIMIT = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HUM_LOW_LIMIT   = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_HUM_HIGH_LIMIT  = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_LIMIT     = 4'd7;

	// Alarm bit positions.
	localparam int ALARM_GAS   = 0;
	localparam int ALARM_FLAME = 1;
	localparam int ALARM_TEMP  = 2;
	localparam int ALARM_HUM   = 3;
	localparam int ALARM_LIGHT = 4;
	localparam int ALARM_W     = 5;

	typedef struct packed {
		logic signed [10:0] temperature;
		logic [9:0]         humidity;
		logic [11:0]        gas_level;
		logic [15:0]        light_level;
		logic               flame;
	} in_t;

	typedef struct packed {
		logic signed [10:0]   avg_temperature;
		logic signed [11:0]   avg_humidity;
		logic [11:0]          avg_gas;
		logic [15:0]          avg_light;
		logic                 reading_valid;
		logic [ALARM_W-1:0]   alarm_level;
		logic [ALARM_W-1:0]   alarm_rise;
	} out_t;

	typedef struct packed {
		logic signed [7:0]  temp_offset;
		logic signed [7:0]  hum_offset;
		logic [11:0]        gas_limit;
		logic signed [10:0] temp_low_limit;
		logic signed [10:0] temp_high_limit;
		logic [9:0]         hum_low_limit;
		logic [9:0]         hum_high_limit;
		logic [15:0]        light_limit;
	} cfg_t;

	// One ring entry: the four averaged channels side by side.
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [HUM_W-1:0]  hum;
		logic [GAS_W-1:0]         gas;
		logic [LIGHT_W-1:0]       light;
	} sample_t;

	// Everything an item carries from acceptance into the update stage.
	typedef struct packed {
		logic               valid;
		logic               prime;
		logic               use_first;
		logic               flame;
		logic [POS_W-1:0]   pos;
		logic signed [11:0] hum_raw;
		sample_t            smp;
	} stage_t;

endpackage
`default_nettype wire

/* sv/sav_cfg_regs.sv */
// Configuration register file of the sensor averaging and alarm block.
`default_nettype none
module sav_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sav_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [sav_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sav_pkg::cfg_t                         cfg
);

	sav_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_offset     <= 8'sd0;
			cfg_q.hum_offset      <= 8'sd0;
			cfg_q.gas_limit       <= 12'd1000;
			cfg_q.temp_low_limit  <= -11'sd100;
			cfg_q.temp_high_limit <= 11'sd400;
			cfg_q.hum_low_limit   <= 10'd200;
			cfg_q.hum_high_limit  <= 10'd800;
			cfg_q.light_limit     <= 16'd500;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sav_pkg::REG_TEMP_OFFSET:     cfg_q.temp_offset     <= cfg_data[7:0];
				sav_pkg::REG_HUM_OFFSET:      cfg_q.hum_offset      <= cfg_data[7:0];
				sav_pkg::REG_GAS_LIMIT:       cfg_q.gas_limit       <= cfg_data[11:0];
				sav_pkg::REG_TEMP_LOW_LIMIT:  cfg_q.temp_low_limit  <= cfg_data[10:0];
				sav_pkg::REG_TEMP_HIGH_LIMIT: cfg_q.temp_high_limit <= cfg_data[10:0];
				sav_pkg::REG_HUM_LOW_LIMIT:   cfg_q.hum_low_limit   <= cfg_data[9:0];
				sav_pkg::REG_HUM_HIGH_LIMIT:  cfg_q.hum_high_limit  <= cfg_data[9:0];
				sav_pkg::REG_LIGHT_LIMIT:     cfg_q.light_limit     <= cfg_data[15:0];
				default: begin
					// Indexes beyond the register list are dropped.
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/sav_ring_mem.sv */
// Sample ring memory: one write port, one read port with registered read data.
`default_nettype none
module sav_ring_mem (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [sav_pkg::POS_W-1:0]  wr_addr,
	input  wire sav_pkg::sample_t           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [sav_pkg::POS_W-1:0]  rd_addr,
	output sav_pkg::sample_t                rd_data
);

	sav_pkg::sample_t mem [sav_pkg::WINDOW_LEN];
	sav_pkg::sample_t rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* sv/sav_accum.sv */
// Running sums, window averages, alarm evaluation and pass-through of invalid readings in the update stage.
`default_nettype none
module sav_accum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sav_pkg::cfg_t      cfg,
	input  wire sav_pkg::stage_t    s1,
	input  wire sav_pkg::sample_t   rd_data,
	input  wire logic               upd,
	output sav_pkg::out_t           result
);

	logic signed [sav_pkg::TEMP_SUM_W-1:0] temp_sum_q, t_base, t_new;
	logic signed [sav_pkg::HUM_SUM_W-1:0]  hum_sum_q, h_base, h_new;
	logic [sav_pkg::GAS_SUM_W-1:0]         gas_sum_q, g_base, g_new;
	logic [sav_pkg::LIGHT_SUM_W-1:0]       light_sum_q, l_base, l_new;
	logic [sav_pkg::ALARM_W-1:0]           alarm_q, level;
	sav_pkg::sample_t                      first_q, old_smp;
	logic signed [sav_pkg::TEMP_W-1:0]     avg_t;
	logic signed [sav_pkg::HUM_W-1:0]      avg_h;
	logic [sav_pkg::GAS_W-1:0]             avg_g;
	logic [sav_pkg::LIGHT_W-1:0]           avg_l;
	logic signed [10:0]                    t_sat;

	// Slots not yet written since the window was primed stand for the first sample.
	always_comb begin
		if (s1.prime) begin
			old_smp = s1.smp;
		end else if (s1.use_first) begin
			old_smp = first_q;
		end else begin
			old_smp = rd_data;
		end
	end

	always_comb begin
		if (s1.prime) begin
			t_base = sav_pkg::TEMP_SUM_W'(s1.smp.temp) <<< sav_pkg::WINDOW_LOG2;
			h_base = sav_pkg::HUM_SUM_W'(s1.smp.hum) <<< sav_pkg::WINDOW_LOG2;
			g_base = sav_pkg::GAS_SUM_W'(s1.smp.gas) << sav_pkg::WINDOW_LOG2;
			l_base = sav_pkg::LIGHT_SUM_W'(s1.smp.light) << sav_pkg::WINDOW_LOG2;
		end else begin
			t_base = temp_sum_q;
			h_base = hum_sum_q;
			g_base = gas_sum_q;
			l_base = light_sum_q;
		end
		t_new = t_base - sav_pkg::TEMP_SUM_W'(old_smp.temp) + sav_pkg::TEMP_SUM_W'(s1.smp.temp);
		h_new = h_base - sav_pkg::HUM_SUM_W'(old_smp.hum) + sav_pkg::HUM_SUM_W'(s1.smp.hum);
		g_new = g_base - sav_pkg::GAS_SUM_W'(old_smp.gas) + sav_pkg::GAS_SUM_W'(s1.smp.gas);
		l_new = l_base - sav_pkg::LIGHT_SUM_W'(old_smp.light)
			+ sav_pkg::LIGHT_SUM_W'(s1.smp.light);
		avg_t = sav_pkg::TEMP_W'(t_new >>> sav_pkg::WINDOW_LOG2);
		avg_h = sav_pkg::HUM_W'(h_new >>> sav_pkg::WINDOW_LOG2);
		avg_g = sav_pkg::GAS_W'(g_new >> sav_pkg::WINDOW_LOG2);
		avg_l = sav_pkg::LIGHT_W'(l_new >> sav_pkg::WINDOW_LOG2);
	end

	always_comb begin
		level = '0;
		level[sav_pkg::ALARM_GAS]   = avg_g > cfg.gas_limit;
		level[sav_pkg::ALARM_FLAME] = s1.flame;
		level[sav_pkg::ALARM_TEMP]  = (avg_t < cfg.temp_low_limit)
			|| (avg_t > cfg.temp_high_limit);
		level[sav_pkg::ALARM_HUM]   = (avg_h < $signed({1'b0, cfg.hum_low_limit}))
			|| (avg_h > $signed({1'b0, cfg.hum_high_limit}));
		level[sav_pkg::ALARM_LIGHT] = avg_l > cfg.light_limit;
	end

	always_comb begin
		if (s1.smp.temp > sav_pkg::TEMP_SAT_MAX) begin
			t_sat = 11'sd1023;
		end else if (s1.smp.temp < sav_pkg::TEMP_SAT_MIN) begin
			t_sat = -11'sd1024;
		end else begin
			t_sat = s1.smp.temp[10:0];
		end
	end

	always_comb begin
		result.reading_valid = s1.valid;
		if (s1.valid) begin
			result.avg_temperature = avg_t[10:0];
			result.avg_humidity    = 12'(avg_h);
			result.avg_gas         = avg_g;
			result.avg_light       = avg_l;
			result.alarm_level     = level;
			result.alarm_rise      = level & ~alarm_q;
		end else begin
			result.avg_temperature = t_sat;
			result.avg_humidity    = s1.hum_raw;
			result.avg_gas         = s1.smp.gas;
			result.avg_light       = s1.smp.light;
			result.alarm_level     = alarm_q;
			result.alarm_rise      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_sum_q  <= '0;
			hum_sum_q   <= '0;
			gas_sum_q   <= '0;
			light_sum_q <= '0;
			alarm_q     <= '0;
		end else if (upd) begin
			temp_sum_q  <= t_new;
			hum_sum_q   <= h_new;
			gas_sum_q   <= g_new;
			light_sum_q <= l_new;
			alarm_q     <= level;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && s1.prime) begin
			first_q <= s1.smp;
		end
	end

endmodule
`default_nettype wire

/* sv/sensor_average_and_alarm.sv */
// Top level: moving-average filter over calibrated sensor readings with threshold alarms.
// A reading is registered into the update stage at its transfer, and its result into
// the output register when that is free. Throughput: one reading per cycle while the
// output is taken; ring read at acceptance, read-modify-write of sums in the update stage.
// Reset clears the control state, running sums, alarm state and configuration
// registers; the ring memory is not cleared, since unwritten slots read as the first sample.
`default_nettype none
module sensor_average_and_alarm (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire sav_pkg::in_t                     in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output sav_pkg::out_t                         out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sav_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [sav_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sav_pkg::cfg_t     cfg;
	sav_pkg::stage_t   stage_in, s1_q;
	sav_pkg::sample_t  rd_data;
	sav_pkg::out_t     result, out_q;
	logic                       s1_valid_s1, out_valid_q;
	logic                       advance, accept, upd;
	logic [sav_pkg::POS_W-1:0]  pos_q;
	logic                       primed_q, wrapped_q;
	logic signed [11:0]         t_cal, h_cal;
	logic                       reading_ok;

	sav_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The output register frees when empty or when its result is being taken.
	// The update stage moves on whenever the output register can take its result,
	// and a new reading is accepted whenever the update stage will be free.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign upd      = s1_valid_s1 && advance && s1_q.valid;

	// Calibration and range check happen at acceptance, so the ring address and
	// the priming decision are known before the memory read is issued.
	always_comb begin
		t_cal = 12'(in_data.temperature) + 12'(cfg.temp_offset);
		h_cal = $signed({2'b00, in_data.humidity}) + 12'(cfg.hum_offset);
		reading_ok = (t_cal >= sav_pkg::TEMP_VALID_MIN) && (t_cal <= sav_pkg::TEMP_VALID_MAX)
			&& (h_cal >= sav_pkg::HUM_VALID_MIN) && (h_cal <= sav_pkg::HUM_VALID_MAX);

		stage_in.valid     = reading_ok;
		stage_in.prime     = !primed_q;
		stage_in.use_first = !wrapped_q;
		stage_in.flame     = in_data.flame;
		stage_in.pos       = pos_q;
		stage_in.hum_raw   = h_cal;
		stage_in.smp.temp  = t_cal;
		stage_in.smp.hum   = h_cal[10:0];
		stage_in.smp.gas   = in_data.gas_level;
		stage_in.smp.light = in_data.light_level;
	end

	// Ring position, priming and first-pass tracking advance with each valid
	// reading at its transfer. The first valid reading primes the window at slot
	// zero; until the position wraps once, the slot about to be replaced has never
	// been written and stands for the priming sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			primed_q  <= 1'b0;
			wrapped_q <= 1'b0;
		end else if (accept && reading_ok) begin
			pos_q    <= pos_q + 1'b1;
			primed_q <= 1'b1;
			if (pos_q == sav_pkg::POS_LAST) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// Consecutive valid readings use different slots, so the slot written by the
	// update stage is never the one being read at the same edge.
	sav_ring_mem u_ring (
		.clk     (clk),
		.wr_en   (upd),
		.wr_addr (s1_q.pos),
		.wr_data (s1_q.smp),
		.rd_en   (accept),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	// Update stage: the sums are read, corrected by the replaced sample and the
	// new one, and written back in the same cycle, so the next reading in the
	// stage always sees the sums left by the one before.
	sav_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s1      (s1_q),
		.rd_data (rd_data),
		.upd     (upd),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= stage_in;
		end
		if (advance && s1_valid_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
